// ===== rtl/owb_pkg.sv =====
// one-wire bus master: shared types, codes and constants
// no dependencies; compiled first

package owb_pkg;

  localparam int COUNTER_WIDTH_DEF = 10;
  localparam int TIMING_W = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int DATA_W = 8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_REL,
    PH_SLOT_LOW,
    PH_WR_HOLD,
    PH_WR_REC,
    PH_RD_SETTLE,
    PH_RD_REST
  } phase_t;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_START_LOW = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITE_HOLD     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITE_RECOVERY = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_SETTLE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_REST      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_RELEASE  = 3'd6;

  localparam logic [TIMING_W-1:0] RST_SLOT_START_LOW = 10'd2;
  localparam logic [TIMING_W-1:0] RST_WRITE_HOLD     = 10'd60;
  localparam logic [TIMING_W-1:0] RST_WRITE_RECOVERY = 10'd2;
  localparam logic [TIMING_W-1:0] RST_READ_SETTLE    = 10'd8;
  localparam logic [TIMING_W-1:0] RST_READ_REST      = 10'd120;
  localparam logic [TIMING_W-1:0] RST_RESET_LOW      = 10'd550;
  localparam logic [TIMING_W-1:0] RST_RESET_RELEASE  = 10'd570;

  typedef struct packed {
    logic [TIMING_W-1:0] slot_start_low;
    logic [TIMING_W-1:0] write_hold;
    logic [TIMING_W-1:0] write_recovery;
    logic [TIMING_W-1:0] read_settle;
    logic [TIMING_W-1:0] read_rest;
    logic [TIMING_W-1:0] reset_low;
    logic [TIMING_W-1:0] reset_release;
  } timing_t;

  typedef struct packed {
    logic              start_req;
    logic [1:0]        mode;
    logic [DATA_W-1:0] write_data;
    logic              line_level;
  } item_t;

  typedef struct packed {
    logic              drive_enable;
    logic              drive_value;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
  } result_t;

endpackage

// ===== rtl/owb_ifs.sv =====
// one-wire bus master: channel interfaces for ticks, results and register writes
// no dependencies beyond the fixed field widths

interface owb_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [1:0] mode;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, start_req, mode, write_data, line_level, input ready);
  modport sink   (input valid, start_req, mode, write_data, line_level, output ready);
endinterface

interface owb_out_if;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_value;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;

  modport source (output valid, drive_enable, drive_value, busy_res, done_res, read_data,
                  input ready);
  modport sink   (input valid, drive_enable, drive_value, busy_res, done_res, read_data,
                  output ready);
endinterface

interface owb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/owb_cfg_regs.sv =====
// one-wire bus master: timing register file behind the write channel
// depends on owb_pkg and owb_cfg_if

module owb_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  owb_cfg_if.sink          cfg,
  output owb_pkg::timing_t timing
);
  import owb_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.slot_start_low <= RST_SLOT_START_LOW;
      timing.write_hold     <= RST_WRITE_HOLD;
      timing.write_recovery <= RST_WRITE_RECOVERY;
      timing.read_settle    <= RST_READ_SETTLE;
      timing.read_rest      <= RST_READ_REST;
      timing.reset_low      <= RST_RESET_LOW;
      timing.reset_release  <= RST_RESET_RELEASE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SLOT_START_LOW: timing.slot_start_low <= cfg.data;
        REG_WRITE_HOLD:     timing.write_hold     <= cfg.data;
        REG_WRITE_RECOVERY: timing.write_recovery <= cfg.data;
        REG_READ_SETTLE:    timing.read_settle    <= cfg.data;
        REG_READ_REST:      timing.read_rest      <= cfg.data;
        REG_RESET_LOW:      timing.reset_low      <= cfg.data;
        REG_RESET_RELEASE:  timing.reset_release  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/owb_engine.sv =====
// one-wire bus master: slot sequencer state and its per-tick update
// depends on owb_pkg; timing comes from owb_cfg_regs

module owb_engine #(
  parameter int COUNTER_WIDTH = owb_pkg::COUNTER_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  owb_pkg::item_t   item,
  input  owb_pkg::timing_t timing,
  output owb_pkg::result_t res,
  output logic             idle
);
  import owb_pkg::*;

  localparam int CMP_W = (COUNTER_WIDTH > TIMING_W) ? COUNTER_WIDTH : TIMING_W;

  phase_t                   phase, phase_next;
  op_t                      operation, operation_next;
  logic [COUNTER_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]               bit_index, bit_index_next;
  logic [DATA_W-1:0]        shift_byte, shift_byte_next;
  logic [DATA_W-1:0]        last_read, last_read_next;

  logic [TIMING_W-1:0] len;
  logic [TIMING_W-1:0] lim_m1;
  logic                ph_end;
  logic                fin;

  assign idle = (phase == PH_IDLE);

  always_comb begin
    phase_next      = phase;
    operation_next  = operation;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    last_read_next  = last_read;
    res             = '0;
    fin             = 1'b0;

    if (phase == PH_IDLE && item.start_req && item.mode <= 2'(OP_READ)) begin
      operation_next  = op_t'(item.mode);
      bit_index_next  = '0;
      tick_count_next = '0;
      shift_byte_next = (item.mode == 2'(OP_WRITE)) ? item.write_data : '0;
      phase_next      = (item.mode == 2'(OP_RESET)) ? PH_RST_LOW : PH_SLOT_LOW;
    end

    case (phase_next)
      PH_RST_LOW:   len = timing.reset_low;
      PH_RST_REL:   len = timing.reset_release;
      PH_SLOT_LOW:  len = timing.slot_start_low;
      PH_WR_HOLD:   len = timing.write_hold;
      PH_WR_REC:    len = timing.write_recovery;
      PH_RD_SETTLE: len = timing.read_settle;
      default:      len = timing.read_rest;
    endcase
    lim_m1 = (len == '0) ? '0 : len - TIMING_W'(1);
    ph_end = (CMP_W'(tick_count_next) >= CMP_W'(lim_m1)) || (&tick_count_next);

    if (phase_next != PH_IDLE) begin
      res.busy_res = 1'b1;
      if (phase_next == PH_RST_LOW || phase_next == PH_SLOT_LOW) begin
        res.drive_enable = 1'b1;
      end else if (phase_next == PH_WR_HOLD) begin
        res.drive_enable = 1'b1;
        res.drive_value  = shift_byte_next[0];
      end

      if (phase_next == PH_RD_REST && tick_count_next == '0) begin
        shift_byte_next = {item.line_level, shift_byte_next[DATA_W-1:1]};
      end

      if (!ph_end) begin
        tick_count_next = tick_count_next + COUNTER_WIDTH'(1);
      end else begin
        tick_count_next = '0;
        case (phase_next)
          PH_RST_LOW:  phase_next = PH_RST_REL;
          PH_RST_REL:  fin = 1'b1;
          PH_SLOT_LOW: phase_next = (operation_next == OP_WRITE) ? PH_WR_HOLD : PH_RD_SETTLE;
          PH_WR_HOLD:  phase_next = PH_WR_REC;
          PH_WR_REC: begin
            shift_byte_next = shift_byte_next >> 1;
            if (bit_index_next == 3'd7) begin
              fin = 1'b1;
            end else begin
              bit_index_next = bit_index_next + 3'd1;
              phase_next     = PH_SLOT_LOW;
            end
          end
          PH_RD_SETTLE: phase_next = PH_RD_REST;
          default: begin
            if (bit_index_next == 3'd7) begin
              fin = 1'b1;
            end else begin
              bit_index_next = bit_index_next + 3'd1;
              phase_next     = PH_SLOT_LOW;
            end
          end
        endcase
      end

      if (fin) begin
        res.done_res = 1'b1;
        phase_next   = PH_IDLE;
        if (operation_next == OP_READ) begin
          last_read_next = shift_byte_next;
        end
      end
    end

    res.read_data = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      operation  <= OP_RESET;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      last_read  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      operation  <= operation_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      last_read  <= last_read_next;
    end
  end

endmodule

// ===== rtl/one_wire_bus_master_unit.sv =====
// one-wire bus master, top level: tick input register, sequencer, result register
// depends on owb_pkg, owb_ifs, owb_cfg_regs and owb_engine
//
// Usage: every transaction on din is one microsecond tick carrying start_req,
// mode (bus reset, write byte, read byte), write_data and the sampled
// line_level. Every tick yields exactly one transaction on dout with
// drive_enable, drive_value, busy_res, done_res and read_data; the pad logic
// drives drive_value onto the line whenever drive_enable is set.
// Timing registers are written over cfg (index 0..6, ten bits each); the user
// must do so only while no operation runs, as the block does not enforce it.
// cfg is always ready and writes beyond index 6 are dropped. A tick taken from
// din sits in the input register, is run through the sequencer and lands in
// the result register, from which it is offered on dout.
// Throughput: one tick per cycle while dout does not stall.
// Reset (rst, synchronous) empties both registers, puts the sequencer in idle
// and loads the default slot timings.
// When dout stalls, the result register holds and the input register keeps
// one more tick; din drops ready only when both are full.

module one_wire_bus_master_unit #(
  parameter int COUNTER_WIDTH = owb_pkg::COUNTER_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  owb_in_if.sink     din,
  owb_out_if.source  dout,
  owb_cfg_if.sink    cfg
);
  import owb_pkg::*;

  timing_t timing;
  item_t   in_item;
  logic    in_valid;
  result_t out_res;
  logic    out_valid;
  result_t step_res;
  logic    eng_idle;
  logic    advance;

  assign advance   = in_valid && (!out_valid || dout.ready);
  assign din.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.ready) begin
      in_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_item <= '{start_req:  din.start_req,
                   mode:       din.mode,
                   write_data: din.write_data,
                   line_level: din.line_level};
    end
  end

  owb_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .timing (timing)
  );

  owb_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .timing (timing),
    .res    (step_res),
    .idle   (eng_idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.drive_enable = out_res.drive_enable;
  assign dout.drive_value  = out_res.drive_value;
  assign dout.busy_res     = out_res.busy_res;
  assign dout.done_res     = out_res.done_res;
  assign dout.read_data    = out_res.read_data;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("buffered tick lost or changed while blocked");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.done_res |=> eng_idle)
    else $error("sequencer not idle after final tick");

  a_drive_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.drive_value |-> out_res.drive_enable && out_res.busy_res)
    else $error("high level driven outside a write slot");

endmodule
